// ===== rtl/core/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Constants, descriptor type, command and status codes and the divider
// request and response types of the page table swap unit.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int ENTRIES    = 30;
    localparam int RESIDENT   = 10;
    localparam int PAGE_BYTES = 1000;

    localparam int USABLE    = ENTRIES - 1;
    localparam int RES_LIMIT = (RESIDENT < USABLE) ? RESIDENT : USABLE;
    localparam int IW        = $clog2(ENTRIES);
    localparam int AVW       = $clog2(USABLE + 1);

    localparam int HW  = 16;
    localparam int LPW = 5;
    localparam int CW  = 16;
    localparam int DW  = 15;
    localparam int NW  = DW + 1;
    localparam int FW  = 4;
    localparam int SW  = 5;

    // reciprocal of the page size, exact for every DW-bit dividend
    localparam int DIV_SH = DW + $clog2(PAGE_BYTES);
    localparam int MW     = DW + 2;
    localparam logic [MW-1:0] DIV_MUL =
        MW'(((64'd1 << DIV_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

    localparam logic [HW-1:0] HANDLE_MAX = '1;
    localparam logic [DW-1:0] QUOT_LIMIT = DW'((1 << LPW) - 1);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOROOM   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [HW-1:0]  handle;
        logic [LPW-1:0] lpage;
        logic [CW-1:0]  count;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
        logic          rem_nz;
    } t_div_rsp;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

// ===== rtl/core/pts_cmd_if.sv =====
// ----------------------------------------------------------------------------
// pts_cmd_if
// Command channel: one item is one table command.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] handle_in;
    logic [14:0] size_bytes;
    logic [14:0] offset;

    modport source (output valid, output cmd, output handle_in, output size_bytes,
                    output offset, input ready);
    modport sink   (input valid, input cmd, input handle_in, input size_bytes,
                    input offset, output ready);
endinterface

// ===== rtl/core/pts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pts_rsp_if
// Response channel: one item per command.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [3:0]  frame;
    logic        swapped;
    logic [4:0]  swap_slot;

    modport source (output valid, output status, output handle_out, output frame,
                    output swapped, output swap_slot, input ready);
    modport sink   (input valid, input status, input handle_out, input frame,
                    input swapped, input swap_slot, output ready);
endinterface

// ===== rtl/core/page_table_lfu_swap_unit.sv =====
// ----------------------------------------------------------------------------
// page_table_lfu_swap_unit
// Page descriptor table with allocate, free and access commands and
// least-used frame exchange, scanned one descriptor per cycle.
// ----------------------------------------------------------------------------
// After accept, the divider runs, then one descriptor a cycle is read through
// the single read port: allocate scans the usable entries twice (once if refused),
// free and a miss scan them once, a hit ends the access scan at its entry, a null
// handle or a page past 31 reads none, and a swap adds a scan of the resident entries.
// One command at a time; the next is taken the cycle after the result enters
// the output register. Reset clears the table at once through per-entry valid bits.
module page_table_lfu_swap_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pts_cmd_if.sink    i_cmd,
    pts_rsp_if.source  o_rsp
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DIV    = 11'b000_0000_0010,
        S_COUNT  = 11'b000_0000_0100,
        S_CHECK  = 11'b000_0000_1000,
        S_FILL   = 11'b000_0001_0000,
        S_FREE   = 11'b000_0010_0000,
        S_FIND   = 11'b000_0100_0000,
        S_MIN    = 11'b000_1000_0000,
        S_SWAP_A = 11'b001_0000_0000,
        S_SWAP_B = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    localparam logic [pts_pkg::IW-1:0] LIM_ALL = pts_pkg::IW'(pts_pkg::USABLE);
    localparam logic [pts_pkg::IW-1:0] LIM_RES = pts_pkg::IW'(pts_pkg::RES_LIMIT);

    t_state                     r_state;
    logic [1:0]                 r_cmd;
    logic [pts_pkg::HW-1:0]     r_handle;
    logic                       r_div_start;
    logic [pts_pkg::DW-1:0]     r_dividend;
    logic [pts_pkg::NW-1:0]     r_need;
    logic [pts_pkg::AVW-1:0]    r_avail;
    logic [pts_pkg::AVW-1:0]    r_lp;
    logic [pts_pkg::LPW-1:0]    r_page;
    logic [pts_pkg::HW-1:0]     r_last_handle;
    logic [pts_pkg::ENTRIES-1:0] r_ent_vld;
    logic [pts_pkg::IW-1:0]     r_raddr;
    logic [pts_pkg::IW-1:0]     r_rd_idx;
    logic                       r_rd_pend;
    logic                       r_rd_ok;
    logic [pts_pkg::IW-1:0]     r_idx;
    logic [pts_pkg::IW-1:0]     r_b;
    logic [pts_pkg::CW-1:0]     r_mn;
    pts_pkg::t_entry            r_acc;
    pts_pkg::t_entry            r_vic;

    logic [1:0]                 r_status;
    logic [pts_pkg::HW-1:0]     r_hout;
    logic [pts_pkg::FW-1:0]     r_frame;
    logic                       r_swp;
    logic [pts_pkg::SW-1:0]     r_slot;

    logic                       r_out_valid;
    logic [1:0]                 r_o_status;
    logic [pts_pkg::HW-1:0]     r_o_hout;
    logic [pts_pkg::FW-1:0]     r_o_frame;
    logic                       r_o_swp;
    logic [pts_pkg::SW-1:0]     r_o_slot;

    pts_pkg::t_div_req          div_req;
    pts_pkg::t_div_rsp          div_rsp;
    logic [pts_pkg::EW-1:0]     ram_q;
    pts_pkg::t_entry            rd_ent;
    pts_pkg::t_entry            bumped;
    logic                       scanning;
    logic [pts_pkg::IW-1:0]     scan_lim;
    logic                       issue;
    logic                       last;
    logic                       hit;
    logic                       is_res;
    logic                       fill_take;
    logic                       free_take;
    logic                       ram_we;
    logic [pts_pkg::IW-1:0]     ram_waddr;
    pts_pkg::t_entry            ram_wdata;
    logic                       div_go;
    logic                       out_load;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_dividend;

    assign div_go   = (r_state == S_IDLE) && i_cmd.valid;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    pts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pts_ram #(
        .WIDTH (pts_pkg::EW),
        .DEPTH (pts_pkg::ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        rd_ent       = r_rd_ok ? pts_pkg::t_entry'(ram_q) : '0;
        bumped       = rd_ent;
        bumped.count = pts_pkg::bump(rd_ent.count);
        scanning     = (r_state == S_COUNT) || (r_state == S_FILL) || (r_state == S_FREE) ||
                       (r_state == S_FIND) || (r_state == S_MIN);
        scan_lim     = (r_state == S_MIN) ? LIM_RES : LIM_ALL;
        hit          = r_rd_pend && (rd_ent.handle == r_handle) && (rd_ent.lpage == r_page);
        issue        = scanning && (r_raddr < scan_lim) && !((r_state == S_FIND) && hit);
        last         = r_rd_pend && (r_rd_idx == scan_lim - 1'b1);
        is_res       = (r_rd_idx < LIM_RES);
        fill_take    = r_rd_pend && (rd_ent.handle == '0) &&
                       (pts_pkg::NW'(r_lp) < r_need);
        free_take    = r_rd_pend && (rd_ent.handle == r_handle);

        ram_we    = 1'b0;
        ram_waddr = r_rd_idx;
        ram_wdata = '0;
        case (r_state)
            S_FILL: begin
                ram_we           = fill_take;
                ram_wdata.handle = r_last_handle;
                ram_wdata.lpage  = pts_pkg::LPW'(r_lp + 1'b1);
                ram_wdata.count  = bumped.count;
            end
            S_FREE: begin
                ram_we = free_take;
            end
            S_FIND: begin
                ram_we    = hit && is_res;
                ram_wdata = bumped;
            end
            S_SWAP_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_b;
                ram_wdata = r_acc;
            end
            S_SWAP_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_vic;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_div_start   <= 1'b0;
            r_rd_pend     <= 1'b0;
            r_ent_vld     <= '0;
            r_last_handle <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_div_start <= div_go;
            if (ram_we) begin
                r_ent_vld[ram_waddr] <= 1'b1;
            end
            r_rd_pend <= issue;
            if (issue) begin
                r_rd_ok  <= r_ent_vld[r_raddr];
                r_rd_idx <= r_raddr;
                r_raddr  <= r_raddr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_o_status  <= r_status;
                r_o_hout    <= r_hout;
                r_o_frame   <= r_frame;
                r_o_swp     <= r_swp;
                r_o_slot    <= r_slot;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd       <= i_cmd.cmd;
                        r_handle    <= i_cmd.handle_in;
                        r_dividend  <= (i_cmd.cmd == pts_pkg::CMD_ALLOC) ?
                                       i_cmd.size_bytes : i_cmd.offset;
                        r_status    <= pts_pkg::ST_OK;
                        r_hout      <= '0;
                        r_frame     <= '0;
                        r_swp       <= 1'b0;
                        r_slot      <= '0;
                        r_avail     <= '0;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_raddr <= '0;
                        case (r_cmd)
                            pts_pkg::CMD_ALLOC: begin
                                r_need  <= pts_pkg::NW'(div_rsp.quot) +
                                           pts_pkg::NW'(div_rsp.rem_nz);
                                r_state <= S_COUNT;
                            end
                            pts_pkg::CMD_FREE: begin
                                r_state <= S_FREE;
                            end
                            default: begin
                                if (r_handle == '0 || div_rsp.quot >= pts_pkg::QUOT_LIMIT) begin
                                    r_status <= pts_pkg::ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_page  <= pts_pkg::LPW'(div_rsp.quot + 1'b1);
                                    r_state <= S_FIND;
                                end
                            end
                        endcase
                    end
                end
                S_COUNT: begin
                    if (r_rd_pend && rd_ent.handle == '0) begin
                        r_avail <= r_avail + 1'b1;
                    end
                    if (last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_last_handle == pts_pkg::HANDLE_MAX ||
                        pts_pkg::NW'(r_avail) < r_need) begin
                        r_status <= pts_pkg::ST_NOROOM;
                        r_state  <= S_DONE;
                    end else begin
                        r_last_handle <= r_last_handle + 1'b1;
                        r_lp          <= '0;
                        r_raddr       <= '0;
                        r_state       <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (fill_take) begin
                        r_lp <= r_lp + 1'b1;
                    end
                    if (last) begin
                        r_hout  <= r_last_handle;
                        r_state <= S_DONE;
                    end
                end
                S_FREE: begin
                    if (last) begin
                        r_state <= S_DONE;
                    end
                end
                S_FIND: begin
                    if (hit) begin
                        r_idx <= r_rd_idx;
                        r_acc <= bumped;
                        if (is_res) begin
                            r_frame <= pts_pkg::FW'(r_rd_idx);
                            r_state <= S_DONE;
                        end else begin
                            r_raddr   <= '0;
                            r_state   <= S_MIN;
                        end
                    end else if (last) begin
                        r_status <= pts_pkg::ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end
                end
                S_MIN: begin
                    // ties go to the higher index
                    if (r_rd_pend && (r_rd_idx == '0 || rd_ent.count <= r_mn)) begin
                        r_mn  <= rd_ent.count;
                        r_b   <= r_rd_idx;
                        r_vic <= rd_ent;
                    end
                    if (last) begin
                        r_state <= S_SWAP_A;
                    end
                end
                S_SWAP_A: begin
                    r_state <= S_SWAP_B;
                end
                S_SWAP_B: begin
                    r_frame <= pts_pkg::FW'(r_b);
                    r_swp   <= 1'b1;
                    r_slot  <= pts_pkg::SW'(r_idx - LIM_RES);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.handle_out = r_o_hout;
    assign o_rsp.frame      = r_o_frame;
    assign o_rsp.swapped    = r_o_swp;
    assign o_rsp.swap_slot  = r_o_slot;

endmodule

// ===== rtl/core/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pts_div.sv =====
// ----------------------------------------------------------------------------
// pts_div
// Division by the page size through a reciprocal multiply: the quotient is
// registered at start, then the remainder flag and done are registered together.
// ----------------------------------------------------------------------------
module pts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pts_pkg::t_div_req i_req,
    output pts_pkg::t_div_rsp o_rsp
);

    localparam int PW = pts_pkg::DW + pts_pkg::MW;

    logic                         r_stage;
    logic                         r_done;
    logic [pts_pkg::DW-1:0]       r_num;
    logic [pts_pkg::DW-1:0]       r_quo;
    logic                         r_rem_nz;
    logic [PW-1:0]                prod;
    logic [pts_pkg::DW-1:0]       back;

    assign prod = PW'(i_req.dividend) * PW'(pts_pkg::DIV_MUL);
    assign back = r_quo * pts_pkg::DW'(pts_pkg::PAGE_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_req.start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_quo <= pts_pkg::DW'(prod >> pts_pkg::DIV_SH);
        end
        if (r_stage) begin
            r_rem_nz <= (back != r_num);
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quo;
    assign o_rsp.rem_nz = r_rem_nz;

endmodule
